[hw/rtl/ufr_pkg.sv]
package ufr_pkg;

   localparam int MAX_PAYLOAD_DEFAULT = 32;
   localparam int RESULT_CAP          = 32;

   localparam int BYTE_W        = 8;
   localparam int LEN_W         = 5;
   localparam int LIMIT_W       = 6;
   localparam int MODE_W        = 2;
   localparam int CSR_INDEX_W   = 3;
   localparam int CSR_DATA_W    = 8;
   localparam int REQ_TDATA_W   = 8;
   localparam int RSP_FIELDS_W  = 2 * BYTE_W + LEN_W;
   localparam int RSP_TDATA_W   = 24;

   localparam logic [MODE_W-1:0]  MODE_LOW        = 2'd1;
   localparam logic [MODE_W-1:0]  MODE_HIGH       = 2'd2;
   localparam logic [MODE_W-1:0]  MODE_RESET      = 2'd0;
   localparam logic [LIMIT_W-1:0] LIMIT_RESET     = 6'd32;

   typedef enum logic [CSR_INDEX_W-1:0] {
      REG_COMM_MODE       = 3'd0,
      REG_HEADER_BYTE     = 3'd1,
      REG_TAIL_BYTE       = 3'd2,
      REG_TYPE_CODE_A     = 3'd3,
      REG_TYPE_CODE_B     = 3'd4,
      REG_OVERFLOW_LIMIT  = 3'd5,
      REG_EXP_LEN_LOW     = 3'd6,
      REG_EXP_LEN_HIGH    = 3'd7
   } ufr_reg_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic latch_len;
      logic latch_kind;
      logic store_byte;
      logic clear_count;
      logic idx_clear;
      logic rd_en;
      logic load_out;
   } ufr_cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic mode_on;
      logic hdr_match;
      logic len_ok;
      logic type_ok;
      logic tail_match;
      logic emit_ok;
      logic store_full;
      logic out_free;
      logic idx_last;
   } ufr_status_type;

endpackage

[hw/rtl/ufr_ram.sv]
module ufr_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 32
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

[hw/rtl/ufr_datapath.sv]
module ufr_datapath #(
   parameter int MAX_PAYLOAD = ufr_pkg::MAX_PAYLOAD_DEFAULT
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              csr_valid,
   output logic                              csr_ready,
   input  logic [ufr_pkg::CSR_INDEX_W-1:0]   csr_index,
   input  logic [ufr_pkg::CSR_DATA_W-1:0]    csr_data,
   input  logic [ufr_pkg::REQ_TDATA_W-1:0]   req_tdata,
   input  ufr_pkg::ufr_cmd_type              cmd,
   output ufr_pkg::ufr_status_type           status,
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   output logic [ufr_pkg::RSP_TDATA_W-1:0]   rsp_tdata,
   output logic                              rsp_tlast
);
   import ufr_pkg::*;

   localparam int AW      = $clog2(MAX_PAYLOAD);
   localparam int CW      = $clog2(MAX_PAYLOAD + 1);
   localparam int LIM_CAP = (MAX_PAYLOAD < RESULT_CAP) ? MAX_PAYLOAD : RESULT_CAP;

   // Configuration registers.
   logic [MODE_W-1:0]  comm_mode_ff;
   logic [BYTE_W-1:0]  header_byte_ff;
   logic [BYTE_W-1:0]  tail_byte_ff;
   logic [BYTE_W-1:0]  type_code_a_ff;
   logic [BYTE_W-1:0]  type_code_b_ff;
   logic [LIMIT_W-1:0] overflow_limit_ff;
   logic [LEN_W-1:0]   exp_len_low_ff;
   logic [LEN_W-1:0]   exp_len_high_ff;

   // Frame state.
   logic [LEN_W-1:0]   frame_len_ff;
   logic [BYTE_W-1:0]  frame_kind_ff;
   logic [CW-1:0]      count_ff;
   logic [CW-1:0]      count_in;
   logic [AW-1:0]      idx_ff;
   logic [AW-1:0]      idx_in;

   // Output register.
   logic                    rsp_valid_ff;
   logic [RSP_FIELDS_W-1:0] rsp_data_ff;
   logic                    rsp_last_ff;

   logic [LIMIT_W-1:0] limit;
   logic [BYTE_W-1:0]  byte_in;
   logic [BYTE_W-1:0]  count_wide;
   logic [BYTE_W-1:0]  count_next_wide;
   logic [BYTE_W-1:0]  len_wide;
   logic [BYTE_W-1:0]  idx_next_wide;
   logic [LEN_W-1:0]   exp_len;
   logic [BYTE_W-1:0]  ram_rd_data;
   logic               ram_wr_en;

   assign csr_ready = 1'b1;
   assign byte_in   = req_tdata[BYTE_W-1:0];

   always_ff @(posedge clock) begin
      if (reset) begin
         comm_mode_ff      <= MODE_RESET;
         header_byte_ff    <= '0;
         tail_byte_ff      <= '0;
         type_code_a_ff    <= '0;
         type_code_b_ff    <= '0;
         overflow_limit_ff <= LIMIT_RESET;
         exp_len_low_ff    <= '0;
         exp_len_high_ff   <= '0;
      end else if (csr_valid) begin
         unique case (ufr_reg_type'(csr_index))
            REG_COMM_MODE:      comm_mode_ff      <= csr_data[MODE_W-1:0];
            REG_HEADER_BYTE:    header_byte_ff    <= csr_data[BYTE_W-1:0];
            REG_TAIL_BYTE:      tail_byte_ff      <= csr_data[BYTE_W-1:0];
            REG_TYPE_CODE_A:    type_code_a_ff    <= csr_data[BYTE_W-1:0];
            REG_TYPE_CODE_B:    type_code_b_ff    <= csr_data[BYTE_W-1:0];
            REG_OVERFLOW_LIMIT: overflow_limit_ff <= csr_data[LIMIT_W-1:0];
            REG_EXP_LEN_LOW:    exp_len_low_ff    <= csr_data[LEN_W-1:0];
            REG_EXP_LEN_HIGH:   exp_len_high_ff   <= csr_data[LEN_W-1:0];
         endcase
      end
   end

   // The limit saturates at the payload depth and at the result cap.
   assign limit = (overflow_limit_ff > LIMIT_W'(LIM_CAP)) ? LIMIT_W'(LIM_CAP)
                                                          : overflow_limit_ff;

   assign count_wide      = BYTE_W'(count_ff);
   assign count_next_wide = BYTE_W'(count_ff) + 8'd1;
   assign len_wide        = BYTE_W'(frame_len_ff);
   assign idx_next_wide   = BYTE_W'(idx_ff) + 8'd1;
   assign exp_len         = (comm_mode_ff == MODE_LOW) ? exp_len_low_ff : exp_len_high_ff;

   always_comb begin
      status.mode_on    = (comm_mode_ff == MODE_LOW) || (comm_mode_ff == MODE_HIGH);
      status.hdr_match  = (byte_in == header_byte_ff);
      status.len_ok     = (byte_in < BYTE_W'(limit));
      status.type_ok    = (byte_in == type_code_a_ff) || (byte_in == type_code_b_ff);
      status.tail_match = (byte_in == tail_byte_ff);
      status.emit_ok    = (count_wide == len_wide) && (frame_len_ff == exp_len)
                          && (frame_len_ff != '0);
      status.store_full = (count_next_wide >= BYTE_W'(limit));
      status.out_free   = !rsp_valid_ff || rsp_tready;
      status.idx_last   = (idx_next_wide == len_wide);
   end

   always_comb begin
      count_in = count_ff;
      if (cmd.clear_count) begin
         count_in = '0;
      end else if (cmd.store_byte) begin
         count_in = count_ff + CW'(1);
      end
      idx_in = idx_ff;
      if (cmd.idx_clear) begin
         idx_in = '0;
      end else if (cmd.load_out) begin
         idx_in = idx_ff + AW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff      <= '0;
         frame_len_ff  <= '0;
         frame_kind_ff <= '0;
         idx_ff        <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         count_ff <= count_in;
         idx_ff   <= idx_in;
         if (cmd.latch_len) begin
            frame_len_ff <= byte_in[LEN_W-1:0];
         end
         if (cmd.latch_kind) begin
            frame_kind_ff <= byte_in;
         end
         if (cmd.load_out) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load_out) begin
         rsp_data_ff <= {frame_len_ff, frame_kind_ff, ram_rd_data};
         rsp_last_ff <= status.idx_last;
      end
   end

   assign ram_wr_en = cmd.store_byte && (count_wide < BYTE_W'(MAX_PAYLOAD));

   ufr_ram #(
      .WIDTH (BYTE_W),
      .DEPTH (MAX_PAYLOAD)
   ) u_payload_ram (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (count_ff[AW-1:0]),
      .wr_data (byte_in),
      .rd_en   (cmd.rd_en),
      .rd_addr (idx_ff),
      .rd_data (ram_rd_data)
   );

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {{(RSP_TDATA_W - RSP_FIELDS_W){1'b0}}, rsp_data_ff};
   assign rsp_tlast  = rsp_last_ff;

`ifndef ASSERT_OFF
   // The payload count never reaches the store depth between bytes.
   a_count_bound : assert property (@(posedge clock) disable iff (reset)
      count_wide < BYTE_W'(MAX_PAYLOAD))
      else $error("payload count reached the store depth");

   // A result is loaded only into a free output register.
   a_load_free : assert property (@(posedge clock) disable iff (reset)
      cmd.load_out |-> (!rsp_valid_ff || rsp_tready))
      else $error("output register overwritten");

   // Every emitted byte lies inside the stored frame.
   a_idx_bound : assert property (@(posedge clock) disable iff (reset)
      cmd.load_out |-> (BYTE_W'(idx_ff) < len_wide))
      else $error("emission index beyond frame length");
`endif

endmodule

[hw/rtl/ufr_ctrl.sv]
module ufr_ctrl (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_tvalid,
   output logic                    req_tready,
   input  ufr_pkg::ufr_status_type status,
   output ufr_pkg::ufr_cmd_type    cmd
);
   import ufr_pkg::*;

   typedef enum logic [2:0] {
      ST_HUNT,
      ST_LEN,
      ST_TYPE,
      ST_PAYLOAD,
      ST_READ,
      ST_LOAD
   } state_type;

   state_type state_ff;
   state_type state_in;
   logic      take;

   assign req_tready = (state_ff == ST_HUNT) || (state_ff == ST_LEN)
                       || (state_ff == ST_TYPE) || (state_ff == ST_PAYLOAD);
   // Bytes taken while the mode is off change nothing.
   assign take = req_tvalid && req_tready && status.mode_on;

   always_comb begin
      cmd      = '0;
      state_in = state_ff;
      unique case (state_ff)
         ST_HUNT: begin
            if (take && status.hdr_match) begin
               state_in = ST_LEN;
            end
         end
         ST_LEN: begin
            if (take) begin
               if (status.len_ok) begin
                  cmd.latch_len = 1'b1;
                  state_in      = ST_TYPE;
               end else begin
                  state_in = ST_HUNT;
               end
            end
         end
         ST_TYPE: begin
            if (take) begin
               if (status.type_ok) begin
                  cmd.latch_kind = 1'b1;
                  state_in       = ST_PAYLOAD;
               end else begin
                  state_in = ST_HUNT;
               end
            end
         end
         ST_PAYLOAD: begin
            if (take) begin
               if (status.tail_match) begin
                  cmd.clear_count = 1'b1;
                  if (status.emit_ok) begin
                     cmd.idx_clear = 1'b1;
                     state_in      = ST_READ;
                  end else begin
                     state_in = ST_HUNT;
                  end
               end else begin
                  cmd.store_byte = 1'b1;
                  if (status.store_full) begin
                     cmd.clear_count = 1'b1;
                     state_in        = ST_HUNT;
                  end
               end
            end
         end
         ST_READ: begin
            cmd.rd_en = 1'b1;
            state_in  = ST_LOAD;
         end
         ST_LOAD: begin
            if (status.out_free) begin
               cmd.load_out = 1'b1;
               state_in     = status.idx_last ? ST_HUNT : ST_READ;
            end
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_HUNT;
      end else begin
         state_ff <= state_in;
      end
   end

`ifndef ASSERT_OFF
   // A memory read is always followed by the load of its data.
   a_read_then_load : assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_READ) |=> (state_ff == ST_LOAD))
      else $error("read not followed by load");

   // A stalled load keeps waiting for the output register.
   a_load_wait : assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_LOAD && !status.out_free) |=> (state_ff == ST_LOAD))
      else $error("load left before output register freed");

   // After the final byte is loaded the parser hunts again.
   a_last_done : assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_LOAD && status.out_free && status.idx_last)
      |=> (state_ff == ST_HUNT))
      else $error("emission did not end after final byte");
`endif

endmodule

[hw/rtl/uart_frame_receiver.sv]
// Emission: after the tail byte is transferred the controller enters the read state, then the load
// state, and repeats both for each further payload byte; a load waits for a free output register.
// Throughput: one received byte per cycle while parsing; during emission the input stalls and
// each result passes through a read state and a load state, as the payload memory read is registered.
// Reset: synchronous, active high; it clears the parser, counters, output valid and the
// configuration registers. The payload memory is not cleared and needs no clearing pass.
module uart_frame_receiver #(
   parameter int MAX_PAYLOAD = ufr_pkg::MAX_PAYLOAD_DEFAULT
) (
   input  logic                             clock,
   input  logic                             reset,
   // Received byte stream.
   input  logic                             req_tvalid,
   output logic                             req_tready,
   input  logic [ufr_pkg::REQ_TDATA_W-1:0]  req_tdata,   // [7:0] rx_byte
   // Payload result stream.
   output logic                             rsp_tvalid,
   input  logic                             rsp_tready,
   // [7:0] payload_byte, [15:8] frame_type, [20:16] frame_length, [23:21] zero
   output logic [ufr_pkg::RSP_TDATA_W-1:0]  rsp_tdata,
   output logic                             rsp_tlast,   // last_byte
   // Configuration write channel.
   input  logic                             csr_valid,
   output logic                             csr_ready,
   input  logic [ufr_pkg::CSR_INDEX_W-1:0]  csr_index,
   input  logic [ufr_pkg::CSR_DATA_W-1:0]   csr_data
);
   import ufr_pkg::*;

   // The controller walks the frame layout (header, length, type, payload, tail) and
   // sequences the payload read-out. The datapath holds the configuration registers,
   // the frame fields, the payload count, the payload memory and the output register.
   ufr_cmd_type    cmd;
   ufr_status_type status;

   ufr_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .status     (status),
      .cmd        (cmd)
   );

   // The output register lets the last result of a frame wait for its transfer
   // while the parser is already taking the next received bytes.
   ufr_datapath #(
      .MAX_PAYLOAD (MAX_PAYLOAD)
   ) u_datapath (
      .clock      (clock),
      .reset      (reset),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data),
      .req_tdata  (req_tdata),
      .cmd        (cmd),
      .status     (status),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast)
   );

endmodule
